@@ hw/rtl/kmwm_pkg.sv @@
`timescale 1ns / 1ps

package kmwm_pkg;

   localparam int MAX_SIDE_DEFAULT = 64;

   localparam int MODE_W       = 2;
   localparam int CELL_FIELD_W = 12;
   localparam int WALLS_W      = 4;
   localparam int STATUS_W     = 2;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 7;

   localparam logic [WALLS_W-1:0] WALL_RIGHT = 4'h1;
   localparam logic [WALLS_W-1:0] WALL_LEFT  = 4'h2;
   localparam logic [WALLS_W-1:0] WALL_DOWN  = 4'h4;
   localparam logic [WALLS_W-1:0] WALL_UP    = 4'h8;
   localparam logic [WALLS_W-1:0] WALL_ALL   = 4'hf;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_START,
      MODE_OFFER,
      MODE_READ,
      MODE_NONE
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_EDGE,
      STATUS_OUTSIDE
   } status_code_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_OUTSIDE,
      RES_EDGE,
      RES_WALLS,
      RES_REMOVED
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_DIVIDE,
      ST_READ_WAIT,
      ST_LOOKUP,
      ST_COMPARE,
      ST_SCAN,
      ST_WALL_CELL,
      ST_WALL_OTHER,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       take;
      logic       clear_start;
      logic       clear_step;
      logic       div_start;
      logic       div_step;
      logic       cap_cell;
      logic       cap_drop;
      logic       scan_start;
      logic       scan_step;
      logic       wall_cell_wr;
      logic       wall_other_wr;
      logic       load_rsp;
      result_type res;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     outside;
      logic     clear_done;
      logic     div_done;
      logic     at_edge;
      logic     same;
      logic     scan_done;
      logic     rsp_free;
   } dp_status_type;

endpackage

@@ hw/rtl/kmwm_channels.sv @@
`timescale 1ns / 1ps

interface kmwm_req_if;
   import kmwm_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [MODE_W-1:0]       mode;
   logic [CELL_FIELD_W-1:0] cell_index;
   logic                    direction;

   modport source (output valid, output mode, output cell_index, output direction,
                   input ready);
   modport sink (input valid, input mode, input cell_index, input direction,
                 output ready);
endinterface

interface kmwm_rsp_if;
   import kmwm_pkg::*;
   logic               valid;
   logic               ready;
   logic               removed;
   logic [WALLS_W-1:0] cell_walls;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output removed, output cell_walls, output status,
                   input ready);
   modport sink (input valid, input removed, input cell_walls, input status,
                 output ready);
endinterface

interface kmwm_csr_if;
   import kmwm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/kmwm_ram.sv @@
`timescale 1ns / 1ps

module kmwm_ram #(
   parameter int WIDTH = kmwm_pkg::WALLS_W,
   parameter int DEPTH = kmwm_pkg::MAX_SIDE_DEFAULT * kmwm_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/kmwm_ctrl.sv @@
`timescale 1ns / 1ps

module kmwm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  kmwm_pkg::dp_status_type stat,
   output kmwm_pkg::cmd_type       cmd
);
   import kmwm_pkg::*;

   state_type  state_ff, state_in;
   result_type res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         res_ff   <= RES_ZERO;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.mode == MODE_START) begin
               cmd.clear_start = 1'b1;
               state_in        = ST_CLEAR;
            end else if (stat.mode == MODE_NONE) begin
               res_in   = RES_ZERO;
               state_in = ST_FINISH;
            end else if (stat.outside) begin
               res_in   = RES_OUTSIDE;
               state_in = ST_FINISH;
            end else if (stat.mode == MODE_READ) begin
               state_in = ST_READ_WAIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_CLEAR: begin
            if (stat.clear_done) begin
               res_in   = RES_ZERO;
               state_in = ST_FINISH;
            end else begin
               cmd.clear_step = 1'b1;
            end
         end
         ST_READ_WAIT: begin
            cmd.cap_cell = 1'b1;
            res_in       = RES_WALLS;
            state_in     = ST_FINISH;
         end
         ST_DIVIDE: begin
            if (stat.div_done) begin
               state_in = ST_LOOKUP;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_LOOKUP: begin
            cmd.cap_cell = 1'b1;
            if (stat.at_edge) begin
               res_in   = RES_EDGE;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.cap_drop = 1'b1;
            if (stat.same) begin
               res_in   = RES_WALLS;
               state_in = ST_FINISH;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_WALL_CELL;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_WALL_CELL: begin
            cmd.wall_cell_wr = 1'b1;
            state_in         = ST_WALL_OTHER;
         end
         ST_WALL_OTHER: begin
            cmd.wall_other_wr = 1'b1;
            res_in            = RES_REMOVED;
            state_in          = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.res = res_ff;
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/kmwm_datapath.sv @@
`timescale 1ns / 1ps

module kmwm_datapath #(
   parameter int MAX_SIDE = kmwm_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kmwm_pkg::cmd_type                    cmd,
   output kmwm_pkg::dp_status_type              stat,
   input  logic [kmwm_pkg::MODE_W-1:0]          req_mode,
   input  logic [kmwm_pkg::CELL_FIELD_W-1:0]    req_cell_index,
   input  logic                                 req_direction,
   input  logic                                 csr_write,
   input  logic [kmwm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kmwm_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_removed,
   output logic [kmwm_pkg::WALLS_W-1:0]         rsp_cell_walls,
   output logic [kmwm_pkg::STATUS_W-1:0]        rsp_status
);
   import kmwm_pkg::*;

   localparam int CELLS  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int TOT_W  = $clog2(CELLS + 1);
   localparam int CNT_W  = $clog2(ADDR_W + 1);
   localparam int CMP_W  = ((CELL_FIELD_W > 2 * SIDE_W) ? CELL_FIELD_W : 2 * SIDE_W) + 1;
   localparam logic [ADDR_W:0]   CLR_END   = (ADDR_W + 1)'(CELLS);
   localparam logic [SIDE_W-1:0] SIDE_MAX  = SIDE_W'(MAX_SIDE);
   localparam logic [CNT_W-1:0]  DIV_STEPS = CNT_W'(ADDR_W);

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [CSR_DATA_W-1:0] v);
      logic [SIDE_W-1:0] s;
      if (v == '0) begin
         s = SIDE_W'(1);
      end else if (int'(v) > MAX_SIDE) begin
         s = SIDE_MAX;
      end else begin
         s = SIDE_W'(v);
      end
      return s;
   endfunction

   logic [SIDE_W-1:0]       width_ff, width_in;
   logic [SIDE_W-1:0]       height_ff, height_in;
   mode_type                mode_ff, mode_in;
   logic [CELL_FIELD_W-1:0] cell_ff, cell_in;
   logic                    dir_ff, dir_in;
   logic [ADDR_W-1:0]       div_sh_ff, div_sh_in;
   logic [CNT_W-1:0]        div_cnt_ff, div_cnt_in;
   logic [SIDE_W-1:0]       rem_ff, rem_in;
   logic [ADDR_W-1:0]       keep_ff, keep_in;
   logic [ADDR_W-1:0]       drop_ff, drop_in;
   logic [WALLS_W-1:0]      walls_ff, walls_in;
   logic [ADDR_W:0]         clr_ff, clr_in;
   logic [TOT_W-1:0]        scan_rd_ff, scan_rd_in;
   logic [ADDR_W-1:0]       scan_wr_ff, scan_wr_in;
   logic                    scan_pend_ff, scan_pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    removed_ff, removed_in;
   logic [WALLS_W-1:0]      walls_out_ff, walls_out_in;
   logic [STATUS_W-1:0]     status_ff, status_in;

   logic [CMP_W-1:0]   total;
   logic [CMP_W-1:0]   cell_cmp;
   logic [CMP_W-1:0]   other_cmp;
   logic [ADDR_W-1:0]  cell_addr;
   logic [ADDR_W-1:0]  other_addr;
   logic [SIDE_W:0]    trial;
   logic               scan_more;
   logic [WALLS_W-1:0] clear_a;
   logic [WALLS_W-1:0] clear_b;

   logic               lbl_wr_en;
   logic [ADDR_W-1:0]  lbl_wr_addr;
   logic [ADDR_W-1:0]  lbl_wr_data;
   logic [ADDR_W-1:0]  lbl_rd_addr;
   logic [ADDR_W-1:0]  lbl_rd_data;
   logic               wal_wr_en;
   logic [ADDR_W-1:0]  wal_wr_addr;
   logic [WALLS_W-1:0] wal_wr_data;
   logic [ADDR_W-1:0]  wal_rd_addr;
   logic [WALLS_W-1:0] wal_rd_data;

   kmwm_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (CELLS)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (lbl_wr_en),
      .wr_addr (lbl_wr_addr),
      .wr_data (lbl_wr_data),
      .rd_addr (lbl_rd_addr),
      .rd_data (lbl_rd_data)
   );

   kmwm_ram #(
      .WIDTH (WALLS_W),
      .DEPTH (CELLS)
   ) u_wall_ram (
      .clock   (clock),
      .wr_en   (wal_wr_en),
      .wr_addr (wal_wr_addr),
      .wr_data (wal_wr_data),
      .rd_addr (wal_rd_addr),
      .rd_data (wal_rd_data)
   );

   assign total      = CMP_W'(width_ff) * CMP_W'(height_ff);
   assign cell_cmp   = CMP_W'(cell_ff);
   assign other_cmp  = dir_ff ? (cell_cmp + CMP_W'(width_ff)) : (cell_cmp + CMP_W'(1));
   assign cell_addr  = ADDR_W'(cell_ff);
   assign other_addr = ADDR_W'(other_cmp);
   assign trial      = {rem_ff, div_sh_ff[ADDR_W-1]};
   assign scan_more  = CMP_W'(scan_rd_ff) < total;
   assign clear_a    = dir_ff ? WALL_DOWN : WALL_RIGHT;
   assign clear_b    = dir_ff ? WALL_UP : WALL_LEFT;

   always_comb begin
      stat.mode       = mode_ff;
      stat.outside    = cell_cmp >= total;
      stat.clear_done = clr_ff == CLR_END;
      stat.div_done   = div_cnt_ff == '0;
      stat.at_edge    = dir_ff ? (other_cmp >= total) : (rem_ff == width_ff - SIDE_W'(1));
      stat.same       = lbl_rd_data == keep_ff;
      stat.scan_done  = !scan_more && !scan_pend_ff;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      mode_in      = mode_ff;
      cell_in      = cell_ff;
      dir_in       = dir_ff;
      div_sh_in    = div_sh_ff;
      div_cnt_in   = div_cnt_ff;
      rem_in       = rem_ff;
      keep_in      = keep_ff;
      drop_in      = drop_ff;
      walls_in     = walls_ff;
      clr_in       = clr_ff;
      scan_rd_in   = scan_rd_ff;
      scan_wr_in   = scan_wr_ff;
      scan_pend_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      removed_in   = removed_ff;
      walls_out_in = walls_out_ff;
      status_in    = status_ff;

      lbl_wr_en   = 1'b0;
      lbl_wr_addr = scan_wr_ff;
      lbl_wr_data = keep_ff;
      lbl_rd_addr = cell_addr;
      wal_wr_en   = 1'b0;
      wal_wr_addr = cell_addr;
      wal_wr_data = walls_ff & ~clear_a;
      wal_rd_addr = cell_addr;

      if (csr_write) begin
         case (csr_index)
            CSR_GRID_WIDTH:  width_in  = clamp_side(csr_data);
            CSR_GRID_HEIGHT: height_in = clamp_side(csr_data);
            default: ;
         endcase
      end

      if (cmd.take) begin
         mode_in = mode_type'(req_mode);
         cell_in = req_cell_index;
         dir_in  = req_direction;
      end

      if (cmd.clear_start) begin
         clr_in = '0;
      end
      if (cmd.clear_step) begin
         lbl_wr_en   = 1'b1;
         lbl_wr_addr = clr_ff[ADDR_W-1:0];
         lbl_wr_data = clr_ff[ADDR_W-1:0];
         wal_wr_en   = 1'b1;
         wal_wr_addr = clr_ff[ADDR_W-1:0];
         wal_wr_data = WALL_ALL;
         clr_in      = clr_ff + 1'b1;
      end

      if (cmd.div_start) begin
         div_sh_in  = cell_addr;
         div_cnt_in = DIV_STEPS;
         rem_in     = '0;
      end
      if (cmd.div_step) begin
         if (trial >= {1'b0, width_ff}) begin
            rem_in = SIDE_W'(trial - {1'b0, width_ff});
         end else begin
            rem_in = SIDE_W'(trial);
         end
         div_sh_in  = div_sh_ff << 1;
         div_cnt_in = div_cnt_ff - 1'b1;
      end

      if (cmd.cap_cell) begin
         keep_in     = lbl_rd_data;
         walls_in    = wal_rd_data;
         lbl_rd_addr = other_addr;
      end
      if (cmd.cap_drop) begin
         drop_in = lbl_rd_data;
      end

      if (cmd.scan_start) begin
         scan_rd_in = '0;
      end
      if (cmd.scan_step && scan_more) begin
         lbl_rd_addr  = ADDR_W'(scan_rd_ff);
         scan_wr_in   = ADDR_W'(scan_rd_ff);
         scan_rd_in   = scan_rd_ff + 1'b1;
         scan_pend_in = 1'b1;
      end
      if (scan_pend_ff && (lbl_rd_data == drop_ff)) begin
         lbl_wr_en   = 1'b1;
         lbl_wr_addr = scan_wr_ff;
         lbl_wr_data = keep_ff;
      end

      if (cmd.wall_cell_wr) begin
         wal_wr_en   = 1'b1;
         wal_wr_addr = cell_addr;
         wal_wr_data = walls_ff & ~clear_a;
         walls_in    = walls_ff & ~clear_a;
         wal_rd_addr = other_addr;
      end
      if (cmd.wall_other_wr) begin
         wal_wr_en   = 1'b1;
         wal_wr_addr = other_addr;
         wal_wr_data = wal_rd_data & ~clear_b;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         case (cmd.res)
            RES_ZERO: begin
               removed_in   = 1'b0;
               walls_out_in = '0;
               status_in    = STATUS_OK;
            end
            RES_OUTSIDE: begin
               removed_in   = 1'b0;
               walls_out_in = '0;
               status_in    = STATUS_OUTSIDE;
            end
            RES_EDGE: begin
               removed_in   = 1'b0;
               walls_out_in = walls_ff;
               status_in    = STATUS_EDGE;
            end
            RES_WALLS: begin
               removed_in   = 1'b0;
               walls_out_in = walls_ff;
               status_in    = STATUS_OK;
            end
            RES_REMOVED: begin
               removed_in   = 1'b1;
               walls_out_in = walls_ff;
               status_in    = STATUS_OK;
            end
            default: begin
               removed_in   = 1'b0;
               walls_out_in = '0;
               status_in    = STATUS_OK;
            end
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIDE_MAX;
         height_ff    <= SIDE_MAX;
         scan_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
         clr_ff       <= CLR_END;
         scan_rd_ff   <= '0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         scan_pend_ff <= scan_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
         clr_ff       <= clr_in;
         scan_rd_ff   <= scan_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      cell_ff      <= cell_in;
      dir_ff       <= dir_in;
      div_sh_ff    <= div_sh_in;
      rem_ff       <= rem_in;
      keep_ff      <= keep_in;
      drop_ff      <= drop_in;
      walls_ff     <= walls_in;
      scan_wr_ff   <= scan_wr_in;
      removed_ff   <= removed_in;
      walls_out_ff <= walls_out_in;
      status_ff    <= status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_removed    = removed_ff;
   assign rsp_cell_walls = walls_out_ff;
   assign rsp_status     = status_ff;

endmodule

@@ hw/rtl/kruskal_maze_wall_merger.sv @@
`timescale 1ns / 1ps
// A start item fills both stores, one entry a cycle. Unused-mode and outside-grid items go
// from decode straight to the result, and a read takes one store read; an offer runs the column
// divider, then stops at the grid edge or compares labels; a merge scans and clears both walls.
// Throughput: one item at a time; the next item is taken the cycle after its result is loaded,
// while that result waits in its register.
// Reset (synchronous, active high) clears control and sets both sides to MAX_SIDE; stores stay
// undefined until the first start item.

module kruskal_maze_wall_merger #(
   parameter int MAX_SIDE = kmwm_pkg::MAX_SIDE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   kmwm_req_if.sink    req_chan,
   kmwm_rsp_if.source  rsp_chan,
   kmwm_csr_if.sink    csr_chan
);
   import kmwm_pkg::*;

   cmd_type       cmd;
   dp_status_type stat;
   logic          req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   kmwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kmwm_datapath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req_chan.mode),
      .req_cell_index (req_chan.cell_index),
      .req_direction  (req_chan.direction),
      .csr_write      (csr_chan.valid),
      .csr_index      (csr_chan.index),
      .csr_data       (csr_chan.data),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_removed    (rsp_chan.removed),
      .rsp_cell_walls (rsp_chan.cell_walls),
      .rsp_status     (rsp_chan.status)
   );

endmodule

@@ bench/tb_kruskal_maze_wall_merger.sv @@
`timescale 1ns / 1ps

module tb_kruskal_maze_wall_merger;
   import kmwm_pkg::*;

   localparam int SIDE_MAX    = MAX_SIDE_DEFAULT;
   localparam int CELL_COUNT  = SIDE_MAX * SIDE_MAX;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int TAIL_CYCLES = 16;
   localparam logic DIR_RIGHT = 1'b0;
   localparam logic DIR_DOWN  = 1'b1;

   typedef struct packed {
      logic               removed;
      logic [WALLS_W-1:0] walls;
      status_code_type    status;
   } maze_answer_type;

   logic clock = 1'b0;
   logic reset;

   kmwm_req_if req_bus();
   kmwm_rsp_if rsp_bus();
   kmwm_csr_if csr_bus();

   maze_answer_type pending_answers[$];

   logic [CELL_FIELD_W-1:0] region_of [CELL_COUNT];
   logic [WALLS_W-1:0]      walls_of [CELL_COUNT];
   int unsigned side_w = SIDE_MAX;
   int unsigned side_h = SIDE_MAX;

   int send_idle_pct;
   int recv_idle_pct;
   int error_count = 0;
   longint cycle_count = 0;

   kruskal_maze_wall_merger dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #5 clock = ~clock;

   function automatic int unsigned clamp_side(input logic [CSR_DATA_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > SIDE_MAX) return SIDE_MAX;
      return 32'(raw);
   endfunction

   function automatic maze_answer_type carve_step(input mode_type m,
                                                  input logic [CELL_FIELD_W-1:0] cell_idx,
                                                  input logic dir);
      maze_answer_type ans;
      int unsigned total;
      int unsigned col;
      int unsigned row;
      int unsigned other;
      logic [CELL_FIELD_W-1:0] keep;
      logic [CELL_FIELD_W-1:0] drop;
      int i;
      ans.removed = 1'b0;
      ans.walls   = '0;
      ans.status  = STATUS_OK;
      total = side_w * side_h;
      if (m == MODE_START) begin
         for (i = 0; i < CELL_COUNT; i++) begin
            region_of[i] = CELL_FIELD_W'(i);
            walls_of[i]  = WALL_ALL;
         end
      end else if (m == MODE_NONE) begin
         ans.status = STATUS_OK;
      end else if (cell_idx >= total) begin
         ans.status = STATUS_OUTSIDE;
      end else if (m == MODE_READ) begin
         ans.walls = walls_of[cell_idx];
      end else begin
         col = cell_idx % side_w;
         row = cell_idx / side_w;
         if ((dir == DIR_RIGHT) ? (col + 1 >= side_w) : (row + 1 >= side_h)) begin
            ans.status = STATUS_EDGE;
            ans.walls  = walls_of[cell_idx];
         end else begin
            other = (dir == DIR_RIGHT) ? cell_idx + 1 : cell_idx + side_w;
            keep  = region_of[cell_idx];
            drop  = region_of[other];
            if (keep != drop) begin
               for (i = 0; i < total; i++) begin
                  if (region_of[i] == drop) region_of[i] = keep;
               end
               if (dir == DIR_RIGHT) begin
                  walls_of[cell_idx] = walls_of[cell_idx] & ~WALL_RIGHT;
                  walls_of[other]    = walls_of[other] & ~WALL_LEFT;
               end else begin
                  walls_of[cell_idx] = walls_of[cell_idx] & ~WALL_DOWN;
                  walls_of[other]    = walls_of[other] & ~WALL_UP;
               end
               ans.removed = 1'b1;
            end
            ans.walls = walls_of[cell_idx];
         end
      end
      return ans;
   endfunction

   task automatic send_item(input mode_type m, input logic [CELL_FIELD_W-1:0] cell_idx,
                            input logic dir);
      maze_answer_type ans;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= m;
      req_bus.cell_index <= cell_idx;
      req_bus.direction  <= dir;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      ans = carve_step(m, cell_idx, dir);
      pending_answers = {pending_answers, ans};
   endtask

   task automatic drain_answers();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic set_grid(input logic [CSR_DATA_W-1:0] raw_w,
                           input logic [CSR_DATA_W-1:0] raw_h);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_GRID_WIDTH;
      csr_bus.data  <= raw_w;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      side_w = clamp_side(raw_w);
      csr_bus.index <= CSR_GRID_HEIGHT;
      csr_bus.data  <= raw_h;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      side_h = clamp_side(raw_h);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_side();
      if ($urandom_range(7) != 0) return CSR_DATA_W'($urandom_range(2, 8));
      case ($urandom_range(3))
         0: return '0;
         1: return CSR_DATA_W'(1);
         2: return CSR_DATA_W'(SIDE_MAX);
         default: return CSR_DATA_W'($urandom_range(SIDE_MAX + 1, 127));
      endcase
   endfunction

   task automatic test_default_grid();
      send_item(MODE_START, 12'd0, DIR_RIGHT);
      send_item(MODE_OFFER, 12'd0, DIR_RIGHT);
      send_item(MODE_OFFER, 12'd0, DIR_RIGHT);
      send_item(MODE_OFFER, 12'd0, DIR_DOWN);
      send_item(MODE_READ, 12'd1, DIR_RIGHT);
      send_item(MODE_READ, 12'd64, DIR_DOWN);
      send_item(MODE_OFFER, 12'd63, DIR_RIGHT);
      send_item(MODE_OFFER, 12'd4095, DIR_RIGHT);
      send_item(MODE_OFFER, 12'd4095, DIR_DOWN);
      send_item(MODE_NONE, 12'd4095, DIR_DOWN);
      send_item(MODE_READ, 12'd4095, DIR_DOWN);
   endtask

   task automatic test_clamped_sides();
      drain_answers();
      set_grid(7'd0, 7'd127);
      send_item(MODE_OFFER, 12'd5, DIR_RIGHT);
      send_item(MODE_OFFER, 12'd5, DIR_DOWN);
      send_item(MODE_READ, 12'd6, DIR_RIGHT);
      send_item(MODE_READ, 12'd64, DIR_RIGHT);
      send_item(MODE_OFFER, 12'd4095, DIR_DOWN);
      drain_answers();
      set_grid(7'd100, 7'd0);
      send_item(MODE_OFFER, 12'd63, DIR_DOWN);
      send_item(MODE_OFFER, 12'd62, DIR_RIGHT);
      send_item(MODE_READ, 12'd64, DIR_DOWN);
      drain_answers();
      set_grid(7'd1, 7'd1);
      send_item(MODE_START, 12'd2730, DIR_DOWN);
      send_item(MODE_OFFER, 12'd0, DIR_RIGHT);
      send_item(MODE_OFFER, 12'd0, DIR_DOWN);
      send_item(MODE_READ, 12'd0, DIR_RIGHT);
      send_item(MODE_READ, 12'd1, DIR_RIGHT);
   endtask

   task automatic test_random_carving(input int send_pct, input int recv_pct,
                                      input int item_goal);
      int sent;
      int run_len;
      int pick;
      int unsigned total;
      logic [CELL_FIELD_W-1:0] cell_idx;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < item_goal) begin
         drain_answers();
         set_grid(pick_side(), pick_side());
         total = side_w * side_h;
         // keep the old stores now and then, so the new sides act on a live maze
         if ($urandom_range(3) != 0) begin
            send_item(MODE_START, CELL_FIELD_W'($urandom_range(0, 4095)),
                      1'($urandom_range(0, 1)));
            sent++;
         end
         run_len = $urandom_range(12, 22);
         repeat (run_len) begin
            if (sent >= item_goal) break;
            pick = $urandom_range(99);
            cell_idx = CELL_FIELD_W'($urandom_range(0, total - 1));
            if (pick < 72)
               send_item(MODE_OFFER, cell_idx, 1'($urandom_range(0, 1)));
            else if (pick < 84)
               send_item(MODE_READ, cell_idx, 1'($urandom_range(0, 1)));
            else if (pick < 93)
               send_item(mode_type'($urandom_range(1, 2)),
                         CELL_FIELD_W'($urandom_range(0, 4095)),
                         1'($urandom_range(0, 1)));
            else
               send_item(MODE_NONE, CELL_FIELD_W'($urandom_range(0, 4095)),
                         1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin : answer_check
      maze_answer_type want;
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected result: removed %0d, cell_walls %0h, status %0d",
                   rsp_bus.removed, rsp_bus.cell_walls, rsp_bus.status);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bus.removed !== want.removed) begin
               $error("removed: expected %0d, actual %0d", want.removed, rsp_bus.removed);
               error_count++;
            end
            if (rsp_bus.cell_walls !== want.walls) begin
               $error("cell_walls: expected %0h, actual %0h", want.walls, rsp_bus.cell_walls);
               error_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[kruskal_maze_wall_merger] ERROR");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.mode       = MODE_START;
      req_bus.cell_index = '0;
      req_bus.direction  = DIR_RIGHT;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_GRID_WIDTH;
      csr_bus.data       = '0;
      send_idle_pct      = 14;
      recv_idle_pct      = 45;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_grid();
      test_clamped_sides();
      test_random_carving(14, 45, 39);
      test_random_carving(45, 14, 39);
      test_random_carving(0, 0, 39);
      drain_answers();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[kruskal_maze_wall_merger] OK");
      else
         $display("[kruskal_maze_wall_merger] ERROR");
      $finish;
   end

endmodule

@@ kruskal_maze_wall_merger.f @@
hw/rtl/kmwm_pkg.sv
hw/rtl/kmwm_channels.sv
hw/rtl/kmwm_ram.sv
hw/rtl/kmwm_ctrl.sv
hw/rtl/kmwm_datapath.sv
hw/rtl/kruskal_maze_wall_merger.sv
bench/tb_kruskal_maze_wall_merger.sv
